// File: hw/rtl/tlgs_pkg.sv
`default_nettype none

package tlgs_pkg;

  localparam int NUM_LABELS_DEF = 3;
  localparam int NUM_TOPICS_DEF = 16;
  localparam int VOCAB_SIZE_DEF = 4096;
  localparam int NUM_DOCS_DEF   = 1024;

  localparam int FUNC_W    = 2;
  localparam int DOC_W     = 10;
  localparam int WORD_W    = 12;
  localparam int LBL_W     = 2;
  localparam int TOP_W     = 4;
  localparam int RAND_W    = 16;
  localparam int PRIOR_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam int CNT_W  = 20;
  localparam int LTC_W  = 24;
  localparam int LPS_W  = 36;
  localparam int ACC_W  = 40;
  localparam int FRAC_W = 24;
  localparam int DIV_W  = 48;
  localparam int BW_W   = 32;
  localparam int BS_W   = 44;
  localparam int MUL_W  = 24;
  localparam int Q_SH   = 16;

  localparam logic [PRIOR_W-1:0] ONE_Q16   = 24'h01_0000;
  localparam logic [PRIOR_W-1:0] ALPHA_RST = 24'd65536;
  localparam logic [PRIOR_W-1:0] BETA_RST  = 24'd655;
  localparam logic [PRIOR_W-1:0] GAMMA_RST = 24'd65536;

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PRIOR    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/tlgs_div.sv
`default_nettype none

module tlgs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tlgs_pkg::div_req_t          req_i,
  output tlgs_pkg::div_stat_t         stat_o,
  output logic [tlgs_pkg::FRAC_W-1:0] quo_o
);
  import tlgs_pkg::*;

  localparam int CNT_BITS = $clog2(FRAC_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]    den_q, den_d;
  logic [FRAC_W-1:0]   quo_q, quo_d;
  logic [DIV_W:0]      rem_sh;
  logic [DIV_W:0]      rem_sub;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      // A fraction of one or more saturates to all ones.
      if (req_i.num >= req_i.den) begin
        quo_d  = '1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = req_i.num;
        den_d  = req_i.den;
        quo_d  = '0;
        cnt_d  = '0;
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sub[DIV_W-1:0];
        quo_d = {quo_q[FRAC_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_W-1:0];
        quo_d = {quo_q[FRAC_W-2:0], 1'b0};
      end
      if (cnt_q == CNT_BITS'(FRAC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/topic_label_gibbs_sampler.sv
// Collapsed Gibbs sampler for a joint sentiment-topic model. Each request carries a func code:
// add a token to the count tables, resample a token's (label, topic) pair, or load one
// label-word prior weight; every request returns exactly one result. After reset the block runs
// a clearing pass over its count memories, one address a cycle, for the largest table depth
// (NUM_LABELS*NUM_TOPICS*VOCAB_SIZE or NUM_DOCS*NUM_LABELS*NUM_TOPICS, 196608 entries at the
// default sizes), and accepts no request until it ends. An add reads and then writes the count
// tables, and a prior load the prior table, before the result is offered. A resample uses the
// shared 24-step restoring divider, once per label and twice per (label, topic) cell, and the
// shared 24x24 multiplier, then searches the cells for the new pair. Division steps end early
// when a ratio saturates.
`default_nettype none

module topic_label_gibbs_sampler #(
  parameter int NUM_LABELS = tlgs_pkg::NUM_LABELS_DEF,
  parameter int NUM_TOPICS = tlgs_pkg::NUM_TOPICS_DEF,
  parameter int VOCAB_SIZE = tlgs_pkg::VOCAB_SIZE_DEF,
  parameter int NUM_DOCS   = tlgs_pkg::NUM_DOCS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlgs_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [tlgs_pkg::PRIOR_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tlgs_pkg::FUNC_W-1:0]    func_i,
  input  logic [tlgs_pkg::DOC_W-1:0]     doc_i,
  input  logic [tlgs_pkg::WORD_W-1:0]    word_i,
  input  logic [tlgs_pkg::LBL_W-1:0]     old_label_i,
  input  logic [tlgs_pkg::TOP_W-1:0]     old_topic_i,
  input  logic [tlgs_pkg::RAND_W-1:0]    rand_u_i,
  input  logic [tlgs_pkg::PRIOR_W-1:0]   prior_weight_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tlgs_pkg::LBL_W-1:0]     new_label_o,
  output logic [tlgs_pkg::TOP_W-1:0]     new_topic_o
);
  import tlgs_pkg::*;

  localparam int LT        = NUM_LABELS * NUM_TOPICS;
  localparam int DT_DEPTH  = NUM_DOCS;
  localparam int DLC_DEPTH = NUM_DOCS * NUM_LABELS;
  localparam int DLT_DEPTH = NUM_DOCS * LT;
  localparam int LTW_DEPTH = LT * VOCAB_SIZE;
  localparam int LWP_DEPTH = NUM_LABELS * VOCAB_SIZE;
  localparam int CLR_LEN   = (DLT_DEPTH > LTW_DEPTH) ? DLT_DEPTH : LTW_DEPTH;

  localparam int DT_AW  = (DT_DEPTH > 1) ? $clog2(DT_DEPTH) : 1;
  localparam int DLC_AW = $clog2(DLC_DEPTH);
  localparam int DLT_AW = $clog2(DLT_DEPTH);
  localparam int LTW_AW = $clog2(LTW_DEPTH);
  localparam int LTC_AW = $clog2(LT);
  localparam int LWP_AW = $clog2(LWP_DEPTH);
  localparam int CLR_AW = $clog2(CLR_LEN);
  localparam int LIW    = $clog2(NUM_LABELS);
  localparam int TIW    = $clog2(NUM_TOPICS);

  localparam logic [LPS_W-1:0] LPS_RST = LPS_W'(64'(VOCAB_SIZE) << Q_SH);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_TM_RD, ST_TM_WR,
    ST_LB_RD, ST_LB_BW, ST_LB_BSL, ST_LB_BSH, ST_LB_F3,
    ST_TP_RD, ST_TP_F1, ST_TP_W1, ST_TP_W2, ST_TP_M1, ST_TP_M2,
    ST_TH_LO, ST_TH_HI, ST_SR_RD, ST_SR_CMP,
    ST_PW_RD, ST_PW_WR, ST_DONE
  } state_e;

  state_e              state_q;
  logic [CLR_AW-1:0]   clr_q;
  logic [LIW-1:0]      a_q;
  logic [TIW-1:0]      b_q;
  logic [LTC_AW-1:0]   c_q;
  logic [LIW-1:0]      cur_l_q;
  logic [TIW-1:0]      cur_t_q;
  logic                add_q;
  logic                pick_q;
  logic                out_valid_q;
  logic [LBL_W-1:0]    out_label_q;
  logic [TOP_W-1:0]    out_topic_q;
  logic [PRIOR_W-1:0]  alpha_q, beta_q, gamma_q;
  logic [LPS_W-1:0]    lps_q [NUM_LABELS];

  logic [DOC_W-1:0]    doc_q;
  logic [WORD_W-1:0]   word_q;
  logic [LBL_W-1:0]    lbl_q;
  logic [TOP_W-1:0]    top_q;
  logic [RAND_W-1:0]   ru_q;
  logic [PRIOR_W-1:0]  pw_q;
  logic [BW_W-1:0]     bw_q;
  logic [BS_W-1:0]     bs_q;
  logic [2*MUL_W-1:0]  pp_q;
  logic [CNT_W-1:0]    dl_q, dlt_q;
  logic [FRAC_W-1:0]   f1_q, f2_q, f3_q, m_q;
  logic [ACC_W-1:0]    acc_q, thr_q;

  logic                tok_ok, lwp_ok, in_acc, in_loop, sc_hit;
  logic [LIW-1:0]      lbl_sel;
  logic [TIW-1:0]      tpc_sel;
  logic [LPS_W-1:0]    lps_sel;
  logic [31:0]         dl_row, cell_idx, clr32;
  logic [31:0]         a_dt, a_dlc, a_dlt, a_ltw, a_ltc, a_lwp;
  logic [DIV_W-1:0]    ngam, nalp;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [2*MUL_W-1:0]  mul_p;
  logic [65:0]         bs_sum;
  logic [71:0]         thr_sum;
  logic [ACC_W-1:0]    acc_nxt;

  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [FRAC_W-1:0]   div_quo;

  logic                dt_we, dlc_we, dlt_we, ltw_we, ltc_we, lwp_we, sc_we;
  logic [CNT_W-1:0]    dt_wd, dlc_wd, dlt_wd, ltw_wd;
  logic [LTC_W-1:0]    ltc_wd;
  logic [PRIOR_W-1:0]  lwp_wd;
  logic [CNT_W-1:0]    dt_rd_q, dlc_rd_q, dlt_rd_q, ltw_rd_q;
  logic [LTC_W-1:0]    ltc_rd_q;
  logic [PRIOR_W-1:0]  lwp_rd_q;
  logic [ACC_W-1:0]    sc_rd_q;

  logic [CNT_W-1:0]    dt_mem  [DT_DEPTH];
  logic [CNT_W-1:0]    dlc_mem [DLC_DEPTH];
  logic [CNT_W-1:0]    dlt_mem [DLT_DEPTH];
  logic [CNT_W-1:0]    ltw_mem [LTW_DEPTH];
  logic [LTC_W-1:0]    ltc_mem [LT];
  logic [PRIOR_W-1:0]  lwp_mem [LWP_DEPTH];
  logic [ACC_W-1:0]    sc_mem  [LT];

  function automatic logic [LTC_W-1:0] cnt_upd(logic [LTC_W-1:0] v, logic [LTC_W-1:0] vmax,
                                               logic up);
    logic [LTC_W-1:0] r;
    r = v;
    if (up) begin
      if (v < vmax) r = v + 1'b1;
    end else begin
      if (v != '0) r = v - 1'b1;
    end
    return r;
  endfunction

  assign tok_ok = (32'(doc_i) < NUM_DOCS) && (32'(word_i) < VOCAB_SIZE) &&
                  (32'(old_label_i) < NUM_LABELS) && (32'(old_topic_i) < NUM_TOPICS);
  assign lwp_ok = (32'(word_i) < VOCAB_SIZE) && (32'(old_label_i) < NUM_LABELS);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign in_loop = (state_q == ST_LB_RD) || (state_q == ST_LB_BW) || (state_q == ST_LB_BSL) ||
                   (state_q == ST_LB_BSH) || (state_q == ST_LB_F3) || (state_q == ST_TP_RD) ||
                   (state_q == ST_TP_F1) || (state_q == ST_TP_W1) || (state_q == ST_TP_W2) ||
                   (state_q == ST_TP_M1) || (state_q == ST_TP_M2);
  assign lbl_sel = in_loop ? a_q : cur_l_q;
  assign tpc_sel = in_loop ? b_q : cur_t_q;
  assign lps_sel = lps_q[lbl_sel];

  assign clr32    = 32'(clr_q);
  assign dl_row   = 32'(doc_q) * 32'(NUM_LABELS) + 32'(lbl_sel);
  assign cell_idx = 32'(lbl_sel) * 32'(NUM_TOPICS) + 32'(tpc_sel);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      a_dt  = clr32;
      a_dlc = clr32;
      a_dlt = clr32;
      a_ltw = clr32;
      a_ltc = clr32;
      a_lwp = clr32;
    end else begin
      a_dt  = 32'(doc_q);
      a_dlc = dl_row;
      a_dlt = dl_row * 32'(NUM_TOPICS) + 32'(tpc_sel);
      a_ltw = cell_idx * 32'(VOCAB_SIZE) + 32'(word_q);
      a_ltc = cell_idx;
      a_lwp = 32'(lbl_sel) * 32'(VOCAB_SIZE) + 32'(word_q);
    end
  end

  always_comb begin
    dt_we  = 1'b0;
    dlc_we = 1'b0;
    dlt_we = 1'b0;
    ltw_we = 1'b0;
    ltc_we = 1'b0;
    lwp_we = 1'b0;
    dt_wd  = CNT_W'(cnt_upd(LTC_W'(dt_rd_q), LTC_W'({CNT_W{1'b1}}), add_q));
    dlc_wd = CNT_W'(cnt_upd(LTC_W'(dlc_rd_q), LTC_W'({CNT_W{1'b1}}), add_q));
    dlt_wd = CNT_W'(cnt_upd(LTC_W'(dlt_rd_q), LTC_W'({CNT_W{1'b1}}), add_q));
    ltw_wd = CNT_W'(cnt_upd(LTC_W'(ltw_rd_q), LTC_W'({CNT_W{1'b1}}), add_q));
    ltc_wd = cnt_upd(ltc_rd_q, {LTC_W{1'b1}}, add_q);
    lwp_wd = pw_q;
    case (state_q)
      ST_CLEAR: begin
        dt_we  = clr32 < DT_DEPTH;
        dlc_we = clr32 < DLC_DEPTH;
        dlt_we = clr32 < DLT_DEPTH;
        ltw_we = clr32 < LTW_DEPTH;
        ltc_we = clr32 < LT;
        lwp_we = clr32 < LWP_DEPTH;
        dt_wd  = '0;
        dlc_wd = '0;
        dlt_wd = '0;
        ltw_wd = '0;
        ltc_wd = '0;
        lwp_wd = ONE_Q16;
      end
      ST_TM_WR: begin
        dt_we  = 1'b1;
        dlc_we = 1'b1;
        dlt_we = 1'b1;
        ltw_we = 1'b1;
        ltc_we = 1'b1;
      end
      ST_PW_WR: begin
        lwp_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dt_we) dt_mem[a_dt[DT_AW-1:0]] <= dt_wd;
    dt_rd_q <= dt_mem[a_dt[DT_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (dlc_we) dlc_mem[a_dlc[DLC_AW-1:0]] <= dlc_wd;
    dlc_rd_q <= dlc_mem[a_dlc[DLC_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (dlt_we) dlt_mem[a_dlt[DLT_AW-1:0]] <= dlt_wd;
    dlt_rd_q <= dlt_mem[a_dlt[DLT_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ltw_we) ltw_mem[a_ltw[LTW_AW-1:0]] <= ltw_wd;
    ltw_rd_q <= ltw_mem[a_ltw[LTW_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ltc_we) ltc_mem[a_ltc[LTC_AW-1:0]] <= ltc_wd;
    ltc_rd_q <= ltc_mem[a_ltc[LTC_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lwp_we) lwp_mem[a_lwp[LWP_AW-1:0]] <= lwp_wd;
    lwp_rd_q <= lwp_mem[a_lwp[LWP_AW-1:0]];
  end

  // Cumulative weights; every entry is written before the search reads it.
  always_ff @(posedge clk_i) begin
    if (sc_we) sc_mem[c_q] <= acc_nxt;
    sc_rd_q <= sc_mem[c_q];
  end

  assign ngam = DIV_W'(gamma_q) * DIV_W'(NUM_LABELS);
  assign nalp = DIV_W'(alpha_q) * DIV_W'(NUM_TOPICS);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = (DIV_W'(dlt_q) << Q_SH) + DIV_W'(alpha_q);
    div_req.den   = (DIV_W'(dl_q) << Q_SH) + nalp;
    case (state_q)
      ST_LB_BW: begin
        div_req.start = 1'b1;
        div_req.num   = (DIV_W'(dlc_rd_q) << Q_SH) + DIV_W'(gamma_q);
        div_req.den   = (DIV_W'(dt_rd_q) << Q_SH) + ngam;
      end
      ST_TP_F1: begin
        div_req.start = 1'b1;
        div_req.num   = (DIV_W'(ltw_rd_q) << Q_SH) + DIV_W'(bw_q);
        div_req.den   = (DIV_W'(ltc_rd_q) << Q_SH) + DIV_W'(bs_q);
      end
      ST_TP_W1: begin
        div_req.start = div_stat.done;
      end
      default: begin
      end
    endcase
  end

  tlgs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  always_comb begin
    mul_a = beta_q;
    mul_b = lwp_rd_q;
    case (state_q)
      ST_LB_BSL: mul_b = MUL_W'(lps_sel[17:0]);
      ST_LB_BSH: mul_b = MUL_W'(lps_sel[35:18]);
      ST_TP_M1: begin
        mul_a = f1_q;
        mul_b = f2_q;
      end
      ST_TP_M2: begin
        mul_a = m_q;
        mul_b = f3_q;
      end
      ST_TH_LO: begin
        mul_a = acc_q[23:0];
        mul_b = MUL_W'(ru_q);
      end
      ST_TH_HI: begin
        mul_a = MUL_W'(acc_q[39:24]);
        mul_b = MUL_W'(ru_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign bs_sum  = {mul_p, 18'b0} + 66'(pp_q);
  assign thr_sum = {mul_p, 24'b0} + 72'(pp_q);
  assign acc_nxt = acc_q + ACC_W'(mul_p[47:24]);
  assign sc_we   = (state_q == ST_TP_M2);
  assign sc_hit  = sc_rd_q > thr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      doc_q  <= doc_i;
      word_q <= word_i;
      lbl_q  <= old_label_i;
      top_q  <= old_topic_i;
      ru_q   <= rand_u_i;
      pw_q   <= prior_weight_i;
      acc_q  <= '0;
    end
    case (state_q)
      ST_LB_BW: begin
        bw_q <= mul_p[47:16];
        dl_q <= dlc_rd_q;
      end
      ST_LB_BSL: pp_q <= mul_p;
      ST_LB_BSH: bs_q <= bs_sum[59:16];
      ST_LB_F3:  f3_q <= div_quo;
      ST_TP_F1:  dlt_q <= dlt_rd_q;
      ST_TP_W1:  f1_q <= div_quo;
      ST_TP_W2:  f2_q <= div_quo;
      ST_TP_M1:  m_q <= mul_p[47:24];
      ST_TP_M2:  acc_q <= acc_nxt;
      ST_TH_LO:  pp_q <= mul_p;
      ST_TH_HI:  thr_q <= thr_sum[55:16];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      cur_l_q     <= '0;
      cur_t_q     <= '0;
      add_q       <= 1'b0;
      pick_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_label_q <= '0;
      out_topic_q <= '0;
      alpha_q     <= ALPHA_RST;
      beta_q      <= BETA_RST;
      gamma_q     <= GAMMA_RST;
      for (int i = 0; i < NUM_LABELS; i++) begin
        lps_q[i] <= LPS_RST;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_ALPHA: alpha_q <= cfg_wdata_i;
          REG_BETA:  beta_q <= cfg_wdata_i;
          REG_GAMMA: gamma_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLR_AW'(CLR_LEN - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cur_l_q <= LIW'(old_label_i);
            cur_t_q <= TIW'(old_topic_i);
            a_q     <= '0;
            b_q     <= '0;
            c_q     <= '0;
            pick_q  <= (func_i == FUNC_RESAMPLE) && tok_ok;
            add_q   <= (func_i == FUNC_ADD);
            case (func_i)
              FUNC_ADD:      state_q <= tok_ok ? ST_TM_RD : ST_DONE;
              FUNC_RESAMPLE: state_q <= tok_ok ? ST_TM_RD : ST_DONE;
              FUNC_PRIOR:    state_q <= lwp_ok ? ST_PW_RD : ST_DONE;
              default:       state_q <= ST_DONE;
            endcase
          end
        end
        ST_TM_RD: state_q <= ST_TM_WR;
        ST_TM_WR: state_q <= add_q ? ST_DONE : ST_LB_RD;
        ST_LB_RD: state_q <= ST_LB_BW;
        ST_LB_BW: state_q <= ST_LB_BSL;
        ST_LB_BSL: state_q <= ST_LB_BSH;
        ST_LB_BSH: state_q <= ST_LB_F3;
        ST_LB_F3: begin
          if (div_stat.done) state_q <= ST_TP_RD;
        end
        ST_TP_RD: state_q <= ST_TP_F1;
        ST_TP_F1: state_q <= ST_TP_W1;
        ST_TP_W1: begin
          if (div_stat.done) state_q <= ST_TP_W2;
        end
        ST_TP_W2: begin
          if (div_stat.done) state_q <= ST_TP_M1;
        end
        ST_TP_M1: state_q <= ST_TP_M2;
        ST_TP_M2: begin
          if (b_q == TIW'(NUM_TOPICS - 1)) begin
            b_q <= '0;
            if (a_q == LIW'(NUM_LABELS - 1)) begin
              a_q     <= '0;
              c_q     <= '0;
              state_q <= ST_TH_LO;
            end else begin
              a_q     <= a_q + 1'b1;
              c_q     <= c_q + 1'b1;
              state_q <= ST_LB_RD;
            end
          end else begin
            b_q     <= b_q + 1'b1;
            c_q     <= c_q + 1'b1;
            state_q <= ST_TP_RD;
          end
        end
        ST_TH_LO: state_q <= ST_TH_HI;
        ST_TH_HI: state_q <= ST_SR_RD;
        ST_SR_RD: state_q <= ST_SR_CMP;
        ST_SR_CMP: begin
          // With no cumulative weight above the threshold the last cell is taken.
          if (sc_hit || (c_q == LTC_AW'(LT - 1))) begin
            cur_l_q <= a_q;
            cur_t_q <= b_q;
            add_q   <= 1'b1;
            state_q <= ST_TM_RD;
          end else begin
            c_q <= c_q + 1'b1;
            if (b_q == TIW'(NUM_TOPICS - 1)) begin
              b_q <= '0;
              a_q <= a_q + 1'b1;
            end else begin
              b_q <= b_q + 1'b1;
            end
            state_q <= ST_SR_RD;
          end
        end
        ST_PW_RD: state_q <= ST_PW_WR;
        ST_PW_WR: begin
          lps_q[cur_l_q] <= lps_q[cur_l_q] + LPS_W'(pw_q) - LPS_W'(lwp_rd_q);
          state_q        <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_label_q <= pick_q ? LBL_W'(cur_l_q) : lbl_q;
            out_topic_q <= pick_q ? TOP_W'(cur_t_q) : top_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_label_o = out_label_q;
  assign new_topic_o = out_topic_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while previous one in progress");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !out_valid_o)
    else $error("result during clearing pass");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_last_cell_picks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SR_CMP) && (c_q == LTC_AW'(LT - 1))) |=> (state_q == ST_TM_RD))
    else $error("search ran past the last cell");

endmodule

`default_nettype wire
